// ----- rtl/wpcm_pkg.sv -----
package wpcm_pkg;

  // operation codes of an input item; the fourth code is unused
  localparam logic [1:0] OP_POLL   = 2'd0;
  localparam logic [1:0] OP_TICK   = 2'd1;
  localparam logic [1:0] OP_STROBE = 2'd2;

  localparam int unsigned COUNT_W   = 32;
  localparam int unsigned RAW_W     = 16;
  localparam int unsigned SPAN_W    = 5;
  localparam int unsigned SHIFT_W   = 64;
  localparam int unsigned REMAIN_W  = 7;

  typedef struct packed {
    logic [1:0]         operation;
    logic [RAW_W-1:0]   raw_pulse;
    logic [RAW_W-1:0]   raw_compare;
    logic               sample_bit;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0]  main_total;
    logic [COUNT_W-1:0]  compare_total;
    logic [COUNT_W-1:0]  window_pulses;
    logic [SPAN_W-1:0]   window_ticks;
    logic                window_valid;
    logic                compare_active;
    logic                compare_agrees;
    logic [COUNT_W-1:0]  main_fast_digits;
    logic [COUNT_W-1:0]  compare_fast_digits;
    logic [SHIFT_W-1:0]  captured_bits;
    logic [REMAIN_W-1:0] bits_left;
  } out_item_t;

  // everything a tick needs from the state stage, taken at the tick
  typedef struct packed {
    logic [COUNT_W-1:0]  main_total;
    logic [COUNT_W-1:0]  compare_total;
    logic [COUNT_W-1:0]  main_delta;
    logic [COUNT_W-1:0]  compare_delta;
    logic [SPAN_W-1:0]   window_ticks;
    logic                window_valid;
    logic                compare_active;
    logic                compare_agrees;
    logic [SHIFT_W-1:0]  captured_bits;
    logic [REMAIN_W-1:0] bits_left;
  } tick_snap_t;

endpackage

// ----- rtl/wpcm_ram.sv -----
module wpcm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 31,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/wpcm_track.sv -----
module wpcm_track #(
  parameter int unsigned WINDOW_TICKS = 30,
  parameter int unsigned PASS_TICKS   = 500,
  parameter int unsigned SAMPLE_BITS  = 64,
  parameter int unsigned RING_AW      = $clog2(WINDOW_TICKS + 1)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              adv,
  input  logic                              item_q_valid,
  input  wpcm_pkg::in_item_t                item_q,
  output logic                              tick,
  output wpcm_pkg::tick_snap_t              snap,
  output logic [RING_AW-1:0]                ring_waddr,
  output logic [RING_AW-1:0]                ring_raddr,
  output logic [wpcm_pkg::COUNT_W-1:0]      ring_wdata
);

  localparam int unsigned RING_DEPTH = WINDOW_TICKS + 1;
  localparam int unsigned IDX_W      = $clog2(PASS_TICKS);
  localparam int unsigned CW         = wpcm_pkg::COUNT_W;
  localparam int unsigned RW         = wpcm_pkg::RAW_W;

  logic [CW-1:0]                  main_extended;
  logic [CW-1:0]                  compare_extended;
  logic [CW-1:0]                  main_previous;
  logic [CW-1:0]                  compare_previous;
  logic                           match_sticky;
  logic [wpcm_pkg::SHIFT_W-1:0]   sample_shift;
  logic [wpcm_pkg::REMAIN_W-1:0]  samples_remaining;
  logic [IDX_W-1:0]               tick_index;
  logic [RING_AW-1:0]             ring_ptr;

  logic [IDX_W-1:0]   tick_index_next;
  logic [RING_AW-1:0] ring_ptr_next;
  logic               match_sticky_next;
  logic               past_window;
  logic               compare_active;
  logic               counts_close;
  logic [CW-1:0]      main_plus_one;
  logic [CW-1:0]      main_minus_one;
  logic               poll;
  logic               strobe;

  function automatic logic [CW-1:0] extend16(input logic [CW-1:0] ext,
                                             input logic [RW-1:0] raw);
    logic [RW-1:0] high;
    high = ext[CW-1:RW];
    if (raw < ext[RW-1:0]) begin
      high = high + RW'(1);
    end
    return {high, raw};
  endfunction

  assign poll   = item_q_valid && (item_q.operation == wpcm_pkg::OP_POLL);
  assign strobe = item_q_valid && (item_q.operation == wpcm_pkg::OP_STROBE);
  assign tick   = item_q_valid && (item_q.operation == wpcm_pkg::OP_TICK);

  assign past_window = 32'(tick_index) > 32'(WINDOW_TICKS);

  assign ring_ptr_next = (ring_ptr == RING_AW'(RING_DEPTH - 1)) ? '0 : ring_ptr + RING_AW'(1);
  assign tick_index_next = (tick_index == IDX_W'(PASS_TICKS - 1)) ? '0
                         : tick_index + IDX_W'(1);

  // window start sits one slot ahead of the write slot once the window is full
  assign ring_waddr = ring_ptr;
  assign ring_raddr = past_window ? ring_ptr_next : '0;
  assign ring_wdata = main_extended;

  assign main_plus_one  = main_extended + CW'(1);
  assign main_minus_one = main_extended - CW'(1);
  assign counts_close   = (compare_extended <= main_plus_one)
                       && (compare_extended >= main_minus_one);
  assign compare_active = compare_extended > CW'(1);
  assign match_sticky_next = match_sticky && (!compare_active || counts_close);

  always_comb begin
    snap.main_total     = main_extended;
    snap.compare_total  = compare_extended;
    snap.main_delta     = main_extended - main_previous;
    snap.compare_delta  = compare_extended - compare_previous;
    snap.window_valid   = tick_index != '0;
    snap.window_ticks   = past_window ? wpcm_pkg::SPAN_W'(WINDOW_TICKS)
                                      : wpcm_pkg::SPAN_W'(tick_index);
    snap.compare_active = compare_active;
    snap.compare_agrees = match_sticky_next;
    snap.captured_bits  = sample_shift;
    snap.bits_left      = samples_remaining;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      main_extended     <= '0;
      compare_extended  <= '0;
      main_previous     <= '0;
      compare_previous  <= '0;
      match_sticky      <= 1'b1;
      sample_shift      <= '0;
      samples_remaining <= wpcm_pkg::REMAIN_W'(SAMPLE_BITS);
      tick_index        <= '0;
      ring_ptr          <= '0;
    end else if (adv) begin
      if (poll) begin
        main_extended    <= extend16(main_extended, item_q.raw_pulse);
        compare_extended <= extend16(compare_extended, item_q.raw_compare);
      end
      if (strobe && (samples_remaining != '0)) begin
        sample_shift      <= {sample_shift[wpcm_pkg::SHIFT_W-2:0], item_q.sample_bit};
        samples_remaining <= samples_remaining - wpcm_pkg::REMAIN_W'(1);
      end
      if (tick) begin
        main_previous    <= main_extended;
        compare_previous <= compare_extended;
        match_sticky     <= match_sticky_next;
        tick_index       <= tick_index_next;
        ring_ptr         <= (tick_index_next == '0) ? '0 : ring_ptr_next;
      end
    end
  end

endmodule

// ----- rtl/wpcm_report.sv -----
module wpcm_report (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic                          tick,
  input  wpcm_pkg::tick_snap_t          snap,
  input  logic [wpcm_pkg::COUNT_W-1:0]  ring_rdata,
  output logic                          result_valid,
  output wpcm_pkg::out_item_t           result
);

  localparam int unsigned CW = wpcm_pkg::COUNT_W;

  logic                 snap_valid;
  wpcm_pkg::tick_snap_t snap_q;
  wpcm_pkg::out_item_t  result_next;

  function automatic logic [CW-1:0] fast_mask(input logic [CW-1:0] delta);
    logic [CW-1:0] m;
    for (int i = 0; i < CW; i++) begin
      m[i] = delta > (CW'(1) << i);
    end
    return m;
  endfunction

  always_comb begin
    result_next.main_total          = snap_q.main_total;
    result_next.compare_total       = snap_q.compare_total;
    result_next.window_pulses       = snap_q.window_valid ? snap_q.main_total - ring_rdata
                                                          : '0;
    result_next.window_ticks        = snap_q.window_ticks;
    result_next.window_valid        = snap_q.window_valid;
    result_next.compare_active      = snap_q.compare_active;
    result_next.compare_agrees      = snap_q.compare_agrees;
    result_next.main_fast_digits    = fast_mask(snap_q.main_delta);
    result_next.compare_fast_digits = fast_mask(snap_q.compare_delta);
    result_next.captured_bits       = snap_q.captured_bits;
    result_next.bits_left           = snap_q.bits_left;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else if (adv) begin
      snap_valid   <= tick;
      result_valid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      snap_q <= snap;
      result <= result_next;
    end
  end

endmodule

// ----- rtl/windowed_pulse_counter_monitor.sv -----
// A display tick's result passes the input register, then the snapshot with the
// registered ring read, then the result register.
// Throughput: one item per cycle of any kind; polls and strobes give no result.
// The whole pipeline stalls only while a result waits and the sink is not ready.
// Reset (synchronous): clears counts, tick index and pipeline valids; sets the
// match flag and the strobe budget. The history ring is not cleared.
module windowed_pulse_counter_monitor #(
  parameter int unsigned WINDOW_TICKS = 30,
  parameter int unsigned PASS_TICKS   = 500,
  parameter int unsigned SAMPLE_BITS  = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  wpcm_pkg::in_item_t   item,
  output logic                 result_valid,
  input  logic                 result_ready,
  output wpcm_pkg::out_item_t  result
);

  localparam int unsigned RING_DEPTH = WINDOW_TICKS + 1;
  localparam int unsigned RING_AW    = $clog2(RING_DEPTH);

  logic                          adv;
  logic                          item_q_valid;
  wpcm_pkg::in_item_t            item_q;
  logic                          tick;
  wpcm_pkg::tick_snap_t          snap;
  logic [RING_AW-1:0]            ring_waddr;
  logic [RING_AW-1:0]            ring_raddr;
  logic [wpcm_pkg::COUNT_W-1:0]  ring_wdata;
  logic [wpcm_pkg::COUNT_W-1:0]  ring_rdata;

  // Every stage moves together; the output register frees up when the
  // sink takes its item, so the pipeline keeps one item per cycle while results are taken.
  assign adv        = !result_valid || result_ready;
  assign item_ready = adv;

  // Input register: the item is registered here before the counter state sees it.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else if (adv) begin
      item_q_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item_q <= item;
    end
  end

  // State stage: extend the raw counters, shift strobe samples, and on a
  // tick take a snapshot and address the history ring.
  wpcm_track #(
    .WINDOW_TICKS (WINDOW_TICKS),
    .PASS_TICKS   (PASS_TICKS),
    .SAMPLE_BITS  (SAMPLE_BITS),
    .RING_AW      (RING_AW)
  ) u_track (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .item_q_valid (item_q_valid),
    .item_q       (item_q),
    .tick         (tick),
    .snap         (snap),
    .ring_waddr   (ring_waddr),
    .ring_raddr   (ring_raddr),
    .ring_wdata   (ring_wdata)
  );

  // History ring: written with the main count on a tick; the window start is read
  // in the same cycle, at another slot except on a pass's first tick, and arrives
  // registered, lined up with the snapshot. Read enable follows adv so a stall holds it.
  wpcm_ram #(
    .WIDTH (wpcm_pkg::COUNT_W),
    .DEPTH (RING_DEPTH),
    .AW    (RING_AW)
  ) u_ring (
    .clk   (clk),
    .we    (adv && tick),
    .waddr (ring_waddr),
    .wdata (ring_wdata),
    .re    (adv),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  // Report stage: window difference, fast-digit masks, output register.
  wpcm_report u_report (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .tick         (tick),
    .snap         (snap),
    .ring_rdata   (ring_rdata),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

// ----- rtl/wpcm_checker.sv -----
module wpcm_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 item_valid,
  input logic                 item_ready,
  input wpcm_pkg::in_item_t   item,
  input logic                 result_valid,
  input logic                 result_ready,
  input wpcm_pkg::out_item_t  result
);

  logic [wpcm_pkg::REMAIN_W-1:0] max_left;

  assign max_left = wpcm_pkg::REMAIN_W'(wpcm_pkg::SHIFT_W);

  a_reset_clears: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result changed");

  a_bits_left: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.bits_left <= max_left)
    else $error("strobe budget out of range");

  a_first_tick: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.window_valid |->
      result.window_ticks == '0 && result.window_pulses == '0)
    else $error("first tick of a pass shows a window");

  a_compare_mode: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.compare_active == (result.compare_total > 32'd1))
    else $error("compare mode disagrees with compare count");

endmodule

bind windowed_pulse_counter_monitor wpcm_checker u_checker (.*);

// ----- verif/wpcm_tick_checker.sv -----
`timescale 1ns / 100ps

module wpcm_tick_checker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  input  logic                 item_ready,
  input  wpcm_pkg::in_item_t   item,
  input  logic                 result_valid,
  input  logic                 result_ready,
  input  wpcm_pkg::out_item_t  result,
  output int unsigned          fail_count,
  output int unsigned          pending_count,
  output int unsigned          result_count
);
  import wpcm_pkg::*;

  localparam int unsigned WINDOW_TICKS = 30;
  localparam int unsigned PASS_TICKS   = 500;
  localparam int unsigned SAMPLE_BITS  = 64;
  localparam int unsigned RING_DEPTH   = WINDOW_TICKS + 1;

  logic [COUNT_W-1:0]  main_count;
  logic [COUNT_W-1:0]  compare_wide;
  logic [COUNT_W-1:0]  main_last;
  logic [COUNT_W-1:0]  compare_last;
  logic [COUNT_W-1:0]  count_ring [RING_DEPTH];
  int unsigned         tick_pos;
  logic                counts_agree;
  logic [SHIFT_W-1:0]  strobe_bits;
  logic [REMAIN_W-1:0] strobes_left;
  out_item_t           tick_reports [$];
  int unsigned         fails = 0;
  int unsigned         matched = 0;

  // widen a 16-bit reading; a reading below the stored low half means a wrap
  function automatic logic [COUNT_W-1:0] extend_count(logic [COUNT_W-1:0] wide,
                                                      logic [RAW_W-1:0] raw);
    logic [RAW_W-1:0] upper;
    upper = wide[COUNT_W-1:RAW_W];
    if (raw < wide[RAW_W-1:0])
      upper = upper + RAW_W'(1);
    return {upper, raw};
  endfunction

  function automatic logic [COUNT_W-1:0] fast_digits(logic [COUNT_W-1:0] delta);
    logic [COUNT_W-1:0] mask;
    mask = '0;
    for (int i = 0; i < COUNT_W; i++)
      mask[i] = delta > (32'd1 << i);
    return mask;
  endfunction

  // advance the tick state and build the report this tick must produce
  function automatic out_item_t tick_report();
    out_item_t   rep;
    int unsigned window_start;
    rep = '0;
    count_ring[tick_pos % RING_DEPTH] = main_count;
    if (tick_pos > 0) begin
      window_start      = (tick_pos > WINDOW_TICKS) ? tick_pos - WINDOW_TICKS : 0;
      rep.window_ticks  = SPAN_W'(tick_pos - window_start);
      rep.window_pulses = main_count - count_ring[window_start % RING_DEPTH];
      rep.window_valid  = 1'b1;
    end
    rep.compare_active = compare_wide > 32'd1;
    if (rep.compare_active && counts_agree)
      counts_agree = (compare_wide <= main_count + 32'd1) &&
                     (compare_wide >= main_count - 32'd1);
    rep.main_total          = main_count;
    rep.compare_total       = compare_wide;
    rep.compare_agrees      = counts_agree;
    rep.main_fast_digits    = fast_digits(main_count - main_last);
    rep.compare_fast_digits = fast_digits(compare_wide - compare_last);
    rep.captured_bits       = strobe_bits;
    rep.bits_left           = strobes_left;
    main_last    = main_count;
    compare_last = compare_wide;
    tick_pos     = (tick_pos + 1 >= PASS_TICKS) ? 0 : tick_pos + 1;
    return rep;
  endfunction

  task automatic check_field(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    if (rst) begin
      main_count    = '0;
      compare_wide  = '0;
      main_last     = '0;
      compare_last  = '0;
      tick_pos      = 0;
      counts_agree  = 1'b1;
      strobe_bits   = '0;
      strobes_left  = REMAIN_W'(SAMPLE_BITS);
      foreach (count_ring[i])
        count_ring[i] = '0;
      tick_reports.delete();
    end else begin
      // results at this edge come from earlier ticks, so compare first
      if (result_valid && result_ready) begin
        if (tick_reports.size() == 0) begin
          $error("result item with no tick report waiting");
          fails++;
        end else begin
          want = tick_reports.pop_front();
          check_field("main_total", 64'(want.main_total), 64'(result.main_total));
          check_field("compare_total", 64'(want.compare_total),
                      64'(result.compare_total));
          check_field("window_pulses", 64'(want.window_pulses),
                      64'(result.window_pulses));
          check_field("window_ticks", 64'(want.window_ticks), 64'(result.window_ticks));
          check_field("window_valid", 64'(want.window_valid), 64'(result.window_valid));
          check_field("compare_active", 64'(want.compare_active),
                      64'(result.compare_active));
          check_field("compare_agrees", 64'(want.compare_agrees),
                      64'(result.compare_agrees));
          check_field("main_fast_digits", 64'(want.main_fast_digits),
                      64'(result.main_fast_digits));
          check_field("compare_fast_digits", 64'(want.compare_fast_digits),
                      64'(result.compare_fast_digits));
          check_field("captured_bits", want.captured_bits, result.captured_bits);
          check_field("bits_left", 64'(want.bits_left), 64'(result.bits_left));
          matched++;
        end
      end
      if (item_valid && item_ready) begin
        case (item.operation)
          OP_POLL: begin
            main_count   = extend_count(main_count, item.raw_pulse);
            compare_wide = extend_count(compare_wide, item.raw_compare);
          end
          OP_TICK: tick_reports.push_back(tick_report());
          OP_STROBE: begin
            if (strobes_left != '0) begin
              strobe_bits  = {strobe_bits[SHIFT_W-2:0], item.sample_bit};
              strobes_left = strobes_left - REMAIN_W'(1);
            end
          end
          default: ;
        endcase
      end
    end
    fail_count    <= fails;
    pending_count <= int'(tick_reports.size());
    result_count  <= matched;
  end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import wpcm_pkg::*;

  // the fourth operation code; the block must ignore it
  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int unsigned RANDOM_ITEMS   = 1230;
  // random items that keep the compare counter within one of the main counter
  localparam int unsigned TRACKING_ITEMS = 600;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_ready;
  in_item_t    item = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  out_item_t   result;

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned result_count;

  // raw counter readings the stimulus walks forward
  logic [RAW_W-1:0] main_raw;
  logic [RAW_W-1:0] compare_raw;
  // when set, neither side idles: back-to-back items
  bit          steady = 1'b0;
  int unsigned poll_cnt = 0;
  int unsigned tick_cnt = 0;
  int unsigned strobe_cnt = 0;
  int unsigned spare_cnt = 0;

  always #5 clk = ~clk;

  windowed_pulse_counter_monitor i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  wpcm_tick_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .item          (item),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .result        (result),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .result_count  (result_count)
  );

  function automatic in_item_t item_of(logic [1:0] op, logic [RAW_W-1:0] pulse,
                                       logic [RAW_W-1:0] cmp, logic level);
    in_item_t it;
    it.operation   = op;
    it.raw_pulse   = pulse;
    it.raw_compare = cmp;
    it.sample_bit  = level;
    return it;
  endfunction

  // step a raw reading: mostly small or medium advances, sometimes a jump
  // anywhere (which may wrap), sometimes no change at all
  function automatic logic [RAW_W-1:0] advance(logic [RAW_W-1:0] raw);
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 4)
      return raw + RAW_W'($urandom_range(0, 3));
    else if (pick < 7)
      return raw + RAW_W'($urandom_range(0, 16'h3fff));
    else if (pick < 9)
      return RAW_W'($urandom);
    return raw;
  endfunction

  // Offer one item: idle for a drawn gap, then hold valid and payload until
  // the block takes it. Returns at the accepting edge.
  task automatic send(in_item_t next);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item       <= next;
    item_valid <= 1'b1;
    do @(posedge clk); while (!(item_valid && item_ready));
    case (next.operation)
      OP_POLL:   poll_cnt++;
      OP_TICK:   tick_cnt++;
      OP_STROBE: strobe_cnt++;
      default:   spare_cnt++;
    endcase
  endtask

  // Result side: stall a drawn number of cycles per item, then hold ready
  // until the item is taken.
  initial begin : sink
    int unsigned stall;
    while (rst) @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!(result_valid && result_ready));
    end
  end

  initial begin : stimulus
    int unsigned pick;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Open with the first tick of a pass: no window yet.
    // Unused fields go to all ones or all zeros along the way.
    send(item_of(OP_TICK, 16'hffff, 16'hffff, 1'b1));
    send(item_of(OP_STROBE, 16'h0000, 16'h0000, 1'b1));
    send(item_of(OP_STROBE, 16'hffff, 16'hffff, 1'b0));
    // unused code with every field high: nothing may change
    send(item_of(OP_SPARE, 16'hffff, 16'hffff, 1'b1));
    // top reading from zero: no wrap yet
    send(item_of(OP_POLL, 16'hffff, 16'hffff, 1'b0));
    send(item_of(OP_TICK, 16'h0000, 16'h0000, 1'b0));
    // both wrap, compare ends one ahead of main
    send(item_of(OP_POLL, 16'h0000, 16'h0001, 1'b1));
    send(item_of(OP_TICK, 16'h0000, 16'h0000, 1'b0));
    // compare one behind main
    send(item_of(OP_POLL, 16'h0002, 16'h0001, 1'b0));
    send(item_of(OP_TICK, 16'h0000, 16'h0000, 1'b1));
    send(item_of(OP_POLL, 16'h0000, 16'h0000, 1'b1));
    send(item_of(OP_TICK, 16'h0000, 16'h0000, 1'b0));
    // tick with no pulses since the last one: empty digit masks
    send(item_of(OP_TICK, 16'hffff, 16'hffff, 1'b1));
    send(item_of(OP_POLL, 16'h8000, 16'h8000, 1'b0));
    send(item_of(OP_TICK, 16'h0000, 16'h0000, 1'b0));
    // two wraps between ticks
    send(item_of(OP_POLL, 16'h0000, 16'h0000, 1'b1));
    send(item_of(OP_POLL, 16'hffff, 16'hffff, 1'b0));
    send(item_of(OP_POLL, 16'h0000, 16'h0000, 1'b1));
    send(item_of(OP_TICK, 16'h0000, 16'h0000, 1'b1));
    main_raw    = '0;
    compare_raw = '0;

    // Random part. Ticks dominate so that the tick index wraps past a full
    // pass; strobes outnumber the sample budget so the register freezes.
    // Early on the compare counter tracks main to keep the match flag alive;
    // later it runs free and breaks it.
    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 50 == 0)
        steady = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        send(item_of(OP_TICK, RAW_W'($urandom), RAW_W'($urandom), 1'($urandom)));
      end else if (pick < 85) begin
        main_raw = advance(main_raw);
        if (i < TRACKING_ITEMS)
          compare_raw = main_raw + RAW_W'($urandom_range(0, 2)) - RAW_W'(1);
        else
          compare_raw = advance(compare_raw);
        send(item_of(OP_POLL, main_raw, compare_raw, 1'($urandom)));
      end else if (pick < 97) begin
        send(item_of(OP_STROBE, RAW_W'($urandom), RAW_W'($urandom), 1'($urandom)));
      end else begin
        send(item_of(OP_SPARE, RAW_W'($urandom), RAW_W'($urandom), 1'($urandom)));
      end
    end
    item_valid <= 1'b0;

    // drain: wait for every tick report, then let the pipeline settle
    do @(posedge clk); while (pending_count != 0);
    repeat (10) @(posedge clk);

    $display("Sent %0d polls, %0d display ticks, %0d strobes, %0d unused-code items;",
             poll_cnt, tick_cnt, strobe_cnt, spare_cnt);
    $display("compared %0d tick reports field by field.", result_count);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // hard stop far beyond the slowest legal run
  initial begin : watchdog
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/wpcm_pkg.sv
rtl/wpcm_ram.sv
rtl/wpcm_track.sv
rtl/wpcm_report.sv
rtl/windowed_pulse_counter_monitor.sv
rtl/wpcm_checker.sv
verif/wpcm_tick_checker.sv
verif/tb_top.sv
